FILE: design/rcs_pkg.sv
// shared types and constants of the ring colour sorter
package rcs_pkg;

    // field widths
    localparam int HUE_W       = 9;
    localparam int PROX_W      = 8;
    localparam int DIST_W      = 14;
    localparam int COUNT_OUT_W = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;

    // colour codes
    typedef logic [1:0] t_color;
    localparam t_color COLOR_NONE = 2'd0;
    localparam t_color COLOR_RED  = 2'd1;
    localparam t_color COLOR_BLUE = 2'd2;

    // proximity a ring must exceed to be classified
    localparam logic [PROX_W-1:0] PROX_MIN = 8'd180;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED_BOUND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_BOUND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SORT_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SORT_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_COLOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ARMED         = 3'd5;

    // register reset values
    localparam logic [HUE_W-1:0]  RED_BOUND_RST     = 9'd20;
    localparam logic [HUE_W-1:0]  BLUE_BOUND_RST    = 9'd180;
    localparam logic [DIST_W-1:0] SORT_DISTANCE_RST = 14'd100;

    // shift control broadcast along the cell row
    typedef struct packed {
        logic   push;
        logic   pop;
        t_color color;
    } t_cell_ctrl;

endpackage

FILE: design/rcs_in_if.sv
// sensor sample channel
interface rcs_in_if;
    import rcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [HUE_W-1:0]    hue;
    logic [PROX_W-1:0]   proximity;
    logic [DIST_W-1:0]   distance;

    modport source (output valid, output hue, output proximity, output distance,
                    input ready);
    modport sink   (input valid, input hue, input proximity, input distance,
                    output ready);
endinterface

FILE: design/rcs_out_if.sv
// sorter result channel
interface rcs_out_if;
    import rcs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   extend_cmd;
    logic                   retract_cmd;
    logic                   ejector_state;
    logic [1:0]             front_color;
    logic [COUNT_OUT_W-1:0] ring_count;
    logic                   overflow;
    logic                   lamp_on;

    modport source (output valid, output extend_cmd, output retract_cmd,
                    output ejector_state, output front_color, output ring_count,
                    output overflow, output lamp_on, input ready);
    modport sink   (input valid, input extend_cmd, input retract_cmd,
                    input ejector_state, input front_color, input ring_count,
                    input overflow, input lamp_on, output ready);
endinterface

FILE: design/rcs_classify.sv
// colour classification and ejector proximity test of one sample
module rcs_classify (
    input  logic [rcs_pkg::HUE_W-1:0]  i_hue,
    input  logic [rcs_pkg::PROX_W-1:0] i_proximity,
    input  logic [rcs_pkg::DIST_W-1:0] i_distance,
    input  logic [rcs_pkg::HUE_W-1:0]  i_red_bound,
    input  logic [rcs_pkg::HUE_W-1:0]  i_blue_bound,
    input  logic [rcs_pkg::DIST_W-1:0] i_sort_distance,
    output rcs_pkg::t_color            o_color,
    output logic                       o_near
);
    import rcs_pkg::*;

    logic w_close;

    // red wins over blue when both bounds match
    assign w_close = (i_proximity > PROX_MIN);

    always_comb begin
        if (w_close && (i_hue < i_red_bound)) begin
            o_color = COLOR_RED;
        end else if (w_close && (i_hue > i_blue_bound)) begin
            o_color = COLOR_BLUE;
        end else begin
            o_color = COLOR_NONE;
        end
    end

    // ring at the ejector
    assign o_near = (i_distance < i_sort_distance);
endmodule

FILE: design/rcs_cell.sv
// one slot of the shifting ring queue; slot 0 is the front
module rcs_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 4
) (
    input  logic                i_clk,
    input  rcs_pkg::t_cell_ctrl i_ctrl,
    input  logic [CNT_W-1:0]    i_count,
    input  rcs_pkg::t_color     i_right_color,
    output rcs_pkg::t_color     o_color,
    output rcs_pkg::t_color     o_next_color
);
    import rcs_pkg::*;

    t_color r_color;
    t_color n_color;
    logic   w_ins_here;
    logic   w_ins_right;

    // new ring lands at slot count, or one slot lower when the queue shifts
    assign w_ins_here  = i_ctrl.push && (i_count == CNT_W'(CELL_IDX));
    assign w_ins_right = i_ctrl.push && (i_count == CNT_W'(CELL_IDX + 1));

    always_comb begin
        if (i_ctrl.pop) begin
            n_color = w_ins_right ? i_ctrl.color : i_right_color;
        end else begin
            n_color = w_ins_here ? i_ctrl.color : r_color;
        end
    end

    // slot contents need no reset: only occupied slots are read
    always_ff @(posedge i_clk) begin
        r_color <= n_color;
    end

    assign o_color      = r_color;
    assign o_next_color = n_color;
endmodule

FILE: design/ring_color_sorter_core.sv
// ring colour sorter: classifier, shifting ring queue of cells and ejector control
//
// One sensor sample is taken per clock while the output side takes results, and
// its result appears in the output register on the next clock. A sample is
// taken whenever the output register is empty or being emptied in the same
// cycle. The ring queue is a row of FIFO_DEPTH cells that shift towards the
// front on each pop, so the front colour is read from the first cell whenever
// the queue holds a ring. Registers are written through the plain write port
// and should only change while no sample is in flight.
module ring_color_sorter_core #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rcs_in_if.sink                          i_in,
    rcs_out_if.source                       o_out
);
    import rcs_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration registers
    logic [HUE_W-1:0]  r_red_bound;
    logic [HUE_W-1:0]  r_blue_bound;
    logic [DIST_W-1:0] r_sort_distance;
    logic              r_sort_enable;
    t_color            r_reject_color;
    logic              r_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_bound     <= RED_BOUND_RST;
            r_blue_bound    <= BLUE_BOUND_RST;
            r_sort_distance <= SORT_DISTANCE_RST;
            r_sort_enable   <= 1'b0;
            r_reject_color  <= COLOR_NONE;
            r_armed         <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RED_BOUND:     r_red_bound     <= i_cfg_data[HUE_W-1:0];
                REG_BLUE_BOUND:    r_blue_bound    <= i_cfg_data[HUE_W-1:0];
                REG_SORT_DISTANCE: r_sort_distance <= i_cfg_data[DIST_W-1:0];
                REG_SORT_ENABLE:   r_sort_enable   <= i_cfg_data[0];
                REG_REJECT_COLOR:  r_reject_color  <= i_cfg_data[1:0];
                REG_ARMED:         r_armed         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // tracking state
    t_color           r_last_color;
    logic             r_last_near;
    logic [CNT_W-1:0] r_count;
    logic             r_ejector;
    logic             r_out_valid;

    t_color           w_color;
    logic             w_near;
    logic             w_accept;
    logic             w_active;
    logic             w_step;
    logic             w_new_color;
    logic             w_full;
    logic             w_push;
    logic             w_ovf;
    logic             w_rise;
    logic             w_fall;
    logic             w_pop;
    t_color           w_front_pre;
    logic             w_extend;
    logic             w_retract;
    logic             n_ejector;
    logic [CNT_W-1:0] n_count;
    t_color           n_front;
    logic [CNT_W+COUNT_OUT_W-1:0] w_count_ext;
    t_cell_ctrl       w_ctrl;
    t_color           w_cell_color [FIFO_DEPTH];
    t_color           w_cell_next  [FIFO_DEPTH];

    // handshake: the output register frees up in the cycle it is taken
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_active   = r_armed && r_sort_enable;
    assign w_step     = w_accept && w_active;

    rcs_classify u_classify (
        .i_hue           (i_in.hue),
        .i_proximity     (i_in.proximity),
        .i_distance      (i_in.distance),
        .i_red_bound     (r_red_bound),
        .i_blue_bound    (r_blue_bound),
        .i_sort_distance (r_sort_distance),
        .o_color         (w_color),
        .o_near          (w_near)
    );

    // push on a change to red or blue, drop when full
    assign w_new_color = w_step && (w_color != r_last_color) && (w_color != COLOR_NONE);
    assign w_full      = (r_count == CNT_W'(FIFO_DEPTH));
    assign w_push      = w_new_color && !w_full;
    assign w_ovf       = w_new_color && w_full;

    // distance edges
    assign w_rise = w_step && w_near && !r_last_near;
    assign w_fall = w_step && !w_near && r_last_near;

    // front seen by the rising edge includes a ring pushed this transaction
    always_comb begin
        if (r_count != '0) begin
            w_front_pre = w_cell_color[0];
        end else if (w_push) begin
            w_front_pre = w_color;
        end else begin
            w_front_pre = COLOR_NONE;
        end
    end

    assign w_pop     = w_rise && ((r_count != '0) || w_push);
    assign w_extend  = w_rise && (w_front_pre == r_reject_color);
    assign w_retract = w_fall && r_ejector;
    assign n_ejector = w_extend ? 1'b1 : (w_retract ? 1'b0 : r_ejector);
    assign n_count   = r_count + CNT_W'(w_push) - CNT_W'(w_pop);
    assign n_front   = (n_count == '0) ? COLOR_NONE : w_cell_next[0];
    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, n_count};

    // row of queue cells
    assign w_ctrl.push  = w_push;
    assign w_ctrl.pop   = w_pop;
    assign w_ctrl.color = w_color;

    for (genvar g = 0; g < FIFO_DEPTH; g++) begin : g_cell
        rcs_cell #(
            .CELL_IDX (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_count       (r_count),
            .i_right_color ((g == FIFO_DEPTH - 1) ? w_color : w_cell_color[(g + 1) % FIFO_DEPTH]),
            .o_color       (w_cell_color[g]),
            .o_next_color  (w_cell_next[g])
        );
    end

    // tracking state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_color <= COLOR_NONE;
            r_last_near  <= 1'b0;
            r_count      <= '0;
            r_ejector    <= 1'b0;
        end else if (w_step) begin
            r_last_color <= w_color;
            r_last_near  <= w_near;
            r_count      <= n_count;
            r_ejector    <= n_ejector;
        end
    end

    // output register
    logic                   r_extend;
    logic                   r_retract;
    logic                   r_ej_state;
    t_color                 r_front;
    logic [COUNT_OUT_W-1:0] r_ring_count;
    logic                   r_overflow;
    logic                   r_lamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_extend     <= w_extend;
            r_retract    <= w_retract;
            r_ej_state   <= n_ejector;
            r_front      <= n_front;
            r_ring_count <= w_count_ext[COUNT_OUT_W-1:0];
            r_overflow   <= w_ovf;
            r_lamp       <= w_active;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.extend_cmd    = r_extend;
    assign o_out.retract_cmd   = r_retract;
    assign o_out.ejector_state = r_ej_state;
    assign o_out.front_color   = r_front;
    assign o_out.ring_count    = r_ring_count;
    assign o_out.overflow      = r_overflow;
    assign o_out.lamp_on       = r_lamp;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("ring count beyond queue depth");

    a_extend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.extend_cmd |-> o_out.ejector_state)
        else $error("extend reported with ejector retracted");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.lamp_on |->
            !o_out.extend_cmd && !o_out.retract_cmd && !o_out.overflow)
        else $error("pulse reported while sorting disabled");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_ovf |=> r_count == CNT_W'(FIFO_DEPTH) || $past(w_pop))
        else $error("overflow without a full queue");
endmodule
